[hdl/cbq_pkg.sv]
`timescale 1ns / 1ps
package cbq_pkg;
    localparam int DataW = 32;
    localparam int CoefW = 12;
    localparam int FbW = 24;
    localparam int GainW = 4;
    localparam int SampleW = 10;
    localparam int CfgIdxW = 3;
    localparam int DefSections = 4;
    localparam logic [CfgIdxW-1:0] REG_GAIN = 3'd4;
    localparam logic [FbW-1:0] FB_RST0 = 24'd2067584;
    localparam logic [FbW-1:0] FB_RST1 = 24'd2067581;
    localparam logic [FbW-1:0] FB_RST2 = 24'd2083966;
    localparam logic [FbW-1:0] FB_RST3 = 24'd2088054;
    localparam logic [GainW-1:0] GAIN_RST = 4'd5;

    function automatic logic signed [DataW-1:0] sat32(input logic signed [DataW+13:0] v);
        logic signed [DataW+13:0] hi;
        logic signed [DataW+13:0] lo;
        begin
            hi = (DataW+14)'(2147483647);
            lo = -hi - (DataW+14)'(1);
            if (v > hi) sat32 = 32'sh7fffffff;
            else if (v < lo) sat32 = 32'sh80000000;
            else sat32 = v[DataW-1:0];
        end
    endfunction

    // truncating divide by 512 (toward zero)
    function automatic logic signed [DataW-1:0] div512(input logic signed [DataW-1:0] v);
        logic signed [DataW-1:0] t;
        begin
            t = v + ((v < 0) ? 32'sd511 : 32'sd0);
            div512 = t >>> 9;
        end
    endfunction
endpackage

[hdl/cbq_sermul.sv]
`timescale 1ns / 1ps
// Shift-add multiplier: signed 32-bit word times signed 12-bit coefficient,
// one coefficient bit per cycle.
module cbq_sermul (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [cbq_pkg::DataW-1:0]        i_a,
    input  logic signed [cbq_pkg::CoefW-1:0]        i_b,
    output logic                                    o_done,
    output logic signed [cbq_pkg::DataW+13:0]       o_p
);
    logic [3:0] r_cnt, n_cnt;
    logic r_busy, n_busy;
    logic signed [cbq_pkg::DataW+13:0] r_acc, n_acc;
    logic signed [cbq_pkg::DataW+13:0] r_a, n_a;
    logic [cbq_pkg::CoefW-1:0] r_b, n_b;
    logic r_done, n_done;

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_acc = r_acc;
        n_a = r_a;
        n_b = r_b;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = 4'd0;
            n_acc = '0;
            n_a = (cbq_pkg::DataW+14)'(i_a);
            n_b = i_b;
        end else if (r_busy) begin
            // top coefficient bit carries negative weight
            if (r_b[0]) begin
                if (r_cnt == 4'(cbq_pkg::CoefW-1)) n_acc = r_acc - r_a;
                else n_acc = r_acc + r_a;
            end
            n_a = r_a <<< 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(cbq_pkg::CoefW-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_done = r_done;
    assign o_p = r_acc;
endmodule

[hdl/cascaded_biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
// Cascaded biquad IIR filter, direct form II, Q9 fixed point.
// Input channel: s_axis (tdata[9:0] = sample, unsigned). Output channel:
// m_axis (tdata[31:0] = filtered, signed). Configuration: plain write port,
// index 0..3 = section feedback words (a1 bits 11:0, a2 bits 23:12),
// index 4 = stage gain; other indexes are ignored.
// Each section needs three multiplies (a1*d1, a2*d0, y*gain) on one shared
// bit-serial multiplier, plus a step for the output sum between the second
// and third multiplies. One item is worked at a time.
// The result waits in an output register; a new sample is taken while it
// waits, but the next result holds until the receiver takes the first.
// Reset (synchronous, active low) clears the delay words and loads the
// default register values; the input is ready as soon as reset is released.
module cascaded_biquad_iir_filter_unit #(
    parameter int SECTIONS = cbq_pkg::DefSections
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,   // [9:0] sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [31:0]                        m_axis_tdata,   // [31:0] filtered
    input  logic                               i_cfg_we,
    input  logic [cbq_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [cbq_pkg::FbW-1:0]            i_cfg_data
);
    localparam int SecW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [2:0] ST_IDLE = 3'd0, ST_M1 = 3'd1, ST_M2 = 3'd2,
                           ST_Y = 3'd3, ST_MG = 3'd4, ST_OUT = 3'd5;

    logic [cbq_pkg::FbW-1:0] r_fb [4];
    logic [cbq_pkg::GainW-1:0] r_gain;
    logic signed [cbq_pkg::DataW-1:0] r_d0 [SECTIONS];
    logic signed [cbq_pkg::DataW-1:0] r_d1 [SECTIONS];
    logic [2:0] r_st, n_st;
    logic [SecW-1:0] r_sec;
    logic signed [cbq_pkg::DataW-1:0] r_x, r_w;
    logic [31:0] r_out;
    logic r_ov;
    logic r_pend;
    logic [cbq_pkg::SampleW-1:0] r_pend_s;
    logic r_mstart, n_mstart;
    logic signed [cbq_pkg::DataW-1:0] r_ma;
    logic signed [cbq_pkg::CoefW-1:0] r_mb;
    logic m_done;
    logic signed [cbq_pkg::DataW+13:0] m_p;

    logic [cbq_pkg::FbW-1:0] fb;
    logic signed [cbq_pkg::CoefW-1:0] a2;
    logic signed [cbq_pkg::DataW-1:0] d0, d1, wq, ysum, b1d1;
    logic s_acc, m_acc;

    cbq_sermul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_mstart),
        .i_a(r_ma), .i_b(r_mb), .o_done(m_done), .o_p(m_p)
    );

    always_comb begin
        fb = r_fb[(int'(r_sec) > 3) ? 2'd3 : 2'(r_sec)];
        a2 = fb[23:12];
        d0 = r_d0[r_sec];
        d1 = r_d1[r_sec];
        wq = cbq_pkg::div512(r_w);
        b1d1 = cbq_pkg::sat32((cbq_pkg::DataW+14)'(d1)
                              * ((int'(r_sec) < 2) ? 46'sd1024 : -46'sd1024));
        ysum = cbq_pkg::sat32((cbq_pkg::DataW+14)'(cbq_pkg::sat32((cbq_pkg::DataW+14)'(wq) * 46'sd512))
                              + (cbq_pkg::DataW+14)'(b1d1));
        ysum = cbq_pkg::sat32((cbq_pkg::DataW+14)'(ysum)
                              + (cbq_pkg::DataW+14)'(cbq_pkg::sat32((cbq_pkg::DataW+14)'(d0) * 46'sd512)));
    end

    assign s_axis_tready = !r_pend;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = r_ov && m_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = r_out;

    always_comb begin
        n_st = r_st;
        n_mstart = 1'b0;
        case (r_st)
            ST_IDLE: if (r_pend) begin
                n_st = ST_M1;
                n_mstart = 1'b1;
            end
            ST_M1:   if (m_done) begin
                n_st = ST_M2;
                n_mstart = 1'b1;
            end
            ST_M2:   if (m_done) n_st = ST_Y;
            ST_Y:    begin
                n_st = ST_MG;
                n_mstart = 1'b1;
            end
            ST_MG:   if (m_done) begin
                if (r_sec == SecW'(SECTIONS-1)) begin
                    n_st = ST_OUT;
                end else begin
                    n_st = ST_M1;
                    n_mstart = 1'b1;
                end
            end
            ST_OUT:  if (!r_ov || m_acc) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb[0] <= cbq_pkg::FB_RST0;
            r_fb[1] <= cbq_pkg::FB_RST1;
            r_fb[2] <= cbq_pkg::FB_RST2;
            r_fb[3] <= cbq_pkg::FB_RST3;
            r_gain <= cbq_pkg::GAIN_RST;
            for (int i = 0; i < SECTIONS; i++) begin
                r_d0[i] <= '0;
                r_d1[i] <= '0;
            end
            r_st <= ST_IDLE;
            r_sec <= '0;
            r_ov <= 1'b0;
            r_pend <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_st <= n_st;
            r_mstart <= n_mstart;
            if (i_cfg_we) begin
                if (i_cfg_idx < cbq_pkg::REG_GAIN) r_fb[i_cfg_idx[1:0]] <= i_cfg_data;
                else if (i_cfg_idx == cbq_pkg::REG_GAIN) r_gain <= i_cfg_data[cbq_pkg::GainW-1:0];
            end
            if (s_acc) begin
                r_pend <= 1'b1;
                r_pend_s <= s_axis_tdata[cbq_pkg::SampleW-1:0];
            end
            // in ST_OUT a taken result is replaced below
            if (m_acc && r_st != ST_OUT) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: if (r_pend) begin
                    r_pend <= 1'b0;
                    r_sec <= '0;
                    r_x <= 32'(r_pend_s);
                    r_ma <= r_d1[0];
                    r_mb <= r_fb[0][11:0];
                end
                ST_M1: if (m_done) begin
                    r_w <= cbq_pkg::sat32((cbq_pkg::DataW+14)'(cbq_pkg::sat32((cbq_pkg::DataW+14)'(r_x) * 46'sd512))
                                          - (cbq_pkg::DataW+14)'(cbq_pkg::sat32(m_p)));
                    r_ma <= d0;
                    r_mb <= a2;
                end
                ST_M2: if (m_done) begin
                    r_w <= cbq_pkg::sat32((cbq_pkg::DataW+14)'(r_w) - (cbq_pkg::DataW+14)'(cbq_pkg::sat32(m_p)));
                end
                ST_Y: begin
                    r_d0[r_sec] <= d1;
                    r_d1[r_sec] <= wq;
                    r_ma <= cbq_pkg::div512(ysum);
                    r_mb <= cbq_pkg::CoefW'(r_gain);
                end
                ST_MG: if (m_done) begin
                    r_x <= cbq_pkg::div512(cbq_pkg::sat32(m_p));
                    if (r_sec != SecW'(SECTIONS-1)) begin
                        r_sec <= r_sec + SecW'(1);
                        r_ma <= r_d1[r_sec + SecW'(1)];
                        r_mb <= r_fb[(int'(r_sec) + 1 > 3) ? 2'd3 : 2'(r_sec + SecW'(1))][11:0];
                    end
                end
                ST_OUT: if (!r_ov || m_acc) begin
                    r_ov <= 1'b1;
                    r_out <= cbq_pkg::sat32((cbq_pkg::DataW+14)'(r_x) + 46'sd512);
                end
                default: ;
            endcase
        end
    end
endmodule

[verif/tb_cascaded_biquad_iir_filter_unit.sv]
`timescale 1ns / 1ps
module tb_cascaded_biquad_iir_filter_unit;
    localparam int NSEC = 4;
    localparam logic [cbq_pkg::CfgIdxW-1:0] REG_FB0 = 3'd0;
    localparam logic [cbq_pkg::CfgIdxW-1:0] REG_FB1 = 3'd1;
    localparam logic [cbq_pkg::CfgIdxW-1:0] REG_FB2 = 3'd2;
    localparam logic [cbq_pkg::CfgIdxW-1:0] REG_FB3 = 3'd3;
    localparam logic [cbq_pkg::CfgIdxW-1:0] REG_BAD = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [9:0] sample
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] filtered
    logic i_cfg_we = 1'b0;
    logic [cbq_pkg::CfgIdxW-1:0] i_cfg_idx = '0;
    logic [cbq_pkg::FbW-1:0] i_cfg_data = '0;

    cascaded_biquad_iir_filter_unit dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic [cbq_pkg::FbW-1:0] fb_word [NSEC];
    logic [cbq_pkg::GainW-1:0] gain_q;
    longint delay_q [2*NSEC];
    logic signed [31:0] filtered_q [$];
    int n_err = 0;
    int n_sent = 0;
    int n_recv = 0;
    bit rx_random = 1'b1;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q9_div(longint v);
        return v / 512;   // longint divide truncates toward zero
    endfunction

    function automatic logic signed [31:0] filter_sample(logic [9:0] smp);
        longint v, a1, a2, b1, d0, d1, w, y;
        logic signed [11:0] c1, c2;
        v = smp;
        for (int s = 0; s < NSEC; s++) begin
            c1 = fb_word[s][11:0];
            c2 = fb_word[s][23:12];
            a1 = c1;
            a2 = c2;
            b1 = (s < 2) ? 1024 : -1024;
            d0 = delay_q[2*s];
            d1 = delay_q[2*s+1];
            w = clip32(v * 512);
            w = clip32(w - clip32(a1 * d1));
            w = clip32(w - clip32(a2 * d0));
            w = q9_div(w);
            y = clip32(512 * w);
            y = clip32(y + clip32(b1 * d1));
            y = clip32(y + clip32(512 * d0));
            y = q9_div(y);
            delay_q[2*s] = d1;
            delay_q[2*s+1] = w;
            v = q9_div(clip32(y * longint'(gain_q)));
        end
        return 32'(clip32(v + 512));
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_sample(logic [9:0] smp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'($urandom), smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        filtered_q.push_back(filter_sample(smp));
        n_sent++;
    endtask

    // result checker and receiver stalls
    initial begin
        logic signed [31:0] exp_v;
        int gap;
        @(posedge i_rst_n);
        forever begin
            m_axis_tready <= rx_random ? ($urandom_range(0, 2) != 0) : 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                n_recv++;
                if (filtered_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %0d", $signed(m_axis_tdata));
                end else begin
                    exp_v = filtered_q.pop_front();
                    if (m_axis_tdata !== exp_v) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("filtered mismatch: exp %0d got %0d", exp_v,
                                     $signed(m_axis_tdata));
                    end
                end
                if (rx_random && $urandom_range(0, 4) == 0) begin
                    gap = $urandom_range(0, 18);
                    if (gap > 0) begin
                        m_axis_tready <= 1'b0;
                        idle_cycles(gap);
                    end
                end
            end
        end
    end

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        idle_cycles(400);
    endtask

    task automatic write_reg(logic [cbq_pkg::CfgIdxW-1:0] idx, logic [cbq_pkg::FbW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < cbq_pkg::REG_GAIN) fb_word[idx] = val;
        else if (idx == cbq_pkg::REG_GAIN) gain_q = val[cbq_pkg::GainW-1:0];
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults;
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd512);
        send_sample(10'd511);
        for (int i = 0; i < 10; i++) send_sample(10'(1 << i));
        for (int i = 0; i < 4; i++) send_sample(~10'(1 << i));
        drain();
    endtask

    task automatic test_saturation;
        write_reg(cbq_pkg::REG_GAIN, 24'hF);
        write_reg(REG_FB0, {12'h800, 12'h800});
        write_reg(REG_FB1, {12'h7FF, 12'h7FF});
        write_reg(REG_FB2, {12'h800, 12'h7FF});
        write_reg(REG_FB3, {12'h7FF, 12'h800});
        write_reg(REG_BAD, 24'hFFFFFF);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 10'd1023 : 10'd0);
        drain();
        write_reg(cbq_pkg::REG_GAIN, 24'hFFFFF0);   // gain zero, upper bits dropped
        for (int i = 0; i < 3; i++) send_sample(10'd1023);
        drain();
    endtask

    task automatic test_random_phase(int n, bit stable);
        for (int r = 0; r < 4; r++)
            write_reg(r[2:0], stable ?
                      {12'($urandom_range(0, 255)), 12'($urandom_range(0, 511))} :
                      24'($urandom));
        write_reg($urandom_range(0, 3) == 0 ? REG_BAD : cbq_pkg::REG_GAIN, 24'($urandom));
        write_reg(cbq_pkg::REG_GAIN, 24'($urandom_range(0, 15)));
        for (int i = 0; i < n; i++)
            send_sample($urandom_range(0, 4) == 0 ? 10'($urandom_range(0, 1) * 1023)
                                                  : 10'($urandom));
        drain();
    endtask

    initial begin
        fb_word[0] = cbq_pkg::FB_RST0;
        fb_word[1] = cbq_pkg::FB_RST1;
        fb_word[2] = cbq_pkg::FB_RST2;
        fb_word[3] = cbq_pkg::FB_RST3;
        gain_q = cbq_pkg::GAIN_RST;
        foreach (delay_q[i]) delay_q[i] = 0;
        idle_cycles(2);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_saturation();
        for (int p = 0; p < 10; p++) begin
            rx_random = (p != 4);
            test_random_phase(110, p[0]);
        end
        rx_random = 1'b1;
        $display("covered %0d samples, %0d results over default, extreme and random registers",
                 n_sent, n_recv);
        $display("feedback extremes, gain 0..15, stalls on both sides");
        if (n_err == 0 && filtered_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

[cascaded_biquad_iir_filter_unit.f]
hdl/cbq_pkg.sv
hdl/cbq_sermul.sv
hdl/cascaded_biquad_iir_filter_unit.sv
verif/tb_cascaded_biquad_iir_filter_unit.sv
